@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker in rtl/alab_checker.sv.
// No dependencies; include once per compilation unit through the guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, masked while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on clk that also holds across reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/alab_pkg.sv @@
// Shared types and constants of the ambient light auto brightness block.
// No dependencies; imported by every module of the block.
`default_nettype none

package alab_pkg;

  // Averaging and range selection
  localparam int unsigned SumW    = 15;
  localparam int unsigned AvgW    = 12;
  localparam int unsigned CodeW   = 16;
  localparam logic [AvgW-1:0] AvgLimit = 12'd4000;

  // Divider range codes
  localparam logic [1:0] RANGE_LOW  = 2'd0;
  localparam logic [1:0] RANGE_MID  = 2'd1;
  localparam logic [1:0] RANGE_HIGH = 2'd2;

  // Ladder thresholds on the light code, brightest-light first
  localparam logic [CodeW-1:0] Thr4   = 16'h8CE4;
  localparam logic [CodeW-1:0] Thr10  = 16'h8C62;
  localparam logic [CodeW-1:0] Thr20  = 16'h8BB8;
  localparam logic [CodeW-1:0] Thr40  = 16'h87D0;
  localparam logic [CodeW-1:0] Thr90  = 16'h8190;
  localparam logic [CodeW-1:0] Thr128 = 16'h47D0;
  localparam logic [CodeW-1:0] Thr196 = 16'h4460;
  localparam logic [CodeW-1:0] Thr255 = 16'h4000;

  // Level stepping
  localparam logic [7:0] BigStep     = 8'd10;
  localparam logic [8:0] BigStepGap  = 9'd9;
  localparam logic [7:0] BigDownMin  = 8'd20;
  localparam logic [1:0] WaitTurn    = 2'd3;
  localparam logic [1:0] WaitSteady  = 2'd2;
  localparam logic [7:0] LevelReset  = 8'd128;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_AUTO_MODE   = 2'd0;
  localparam logic [1:0] REG_NEVER_OFF   = 2'd1;
  localparam logic [1:0] REG_MANUAL_BRT  = 2'd2;

  typedef struct packed {
    logic       auto_mode;
    logic       never_off;
    logic [7:0] manual_brightness;
  } alab_cfg_t;

  typedef struct packed {
    logic [7:0]      target;
    logic [1:0]      range_mode;
    logic [AvgW-1:0] light_value;
  } alab_light_t;

endpackage

`default_nettype wire

@@ rtl/ambient_light_auto_brightness.sv @@
// Top level of the ambient light auto brightness block.
// Depends on alab_pkg, alab_light and alab_level.
//
// Usage:
//   in_*   : stream of sample sets (three 15-bit sums of 8 ADC readings plus
//            the key-hold flag in in_tuser). One transfer per accepted set.
//   out_*  : one result per sample set: brightness, target, range and
//            averaged light value in out_tdata, brightness_changed in out_tuser.
//   cfg_*  : APB register port; 0x0 auto_mode, 0x4 never_off,
//            0x8 manual_brightness. Write only while the block is idle.
// Path: an accepted input is held in the input register, then in the result
//   register, where it is valid. Throughput: one item per cycle while
//   out_tready is high; the level update is a single compare/add path from
//   the input register to the result register and the level register.
// Reset (rst_n low, synchronous): both stages empty, level 128, countdowns
//   zero, registers at auto_mode 1, never_off 0, manual_brightness 128.
// Stall: while out_tready is low the result holds; one more item can wait
//   in the input register, after which in_tready drops.
`default_nettype none

module ambient_light_auto_brightness
  import alab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // [14:0] sum_low_resistor, [29:15] sum_mid_resistor,
                                      // [44:30] sum_high_resistor, [47:45] zero
  input  wire logic        in_tuser,  // [0] hold_on
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata, // [7:0] brightness, [15:8] target_brightness,
                                      // [17:16] range_mode, [29:18] light_value, [31:30] zero
  output logic             out_tuser, // [0] brightness_changed
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  alab_cfg_t cfg_r;
  logic      cfg_wr;

  logic            s1_valid_r, s1_valid_nxt;
  logic [SumW-1:0] s1_low_r, s1_mid_r, s1_high_r;
  logic            s1_hold_r;
  logic            s1_adv;
  logic            in_xfer;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;
  logic        out_user_r;

  alab_light_t light;
  logic [7:0]  level_next;
  logic        level_changed;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_mode         <= 1'b1;
      cfg_r.never_off         <= 1'b0;
      cfg_r.manual_brightness <= LevelReset;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_AUTO_MODE:  cfg_r.auto_mode         <= cfg_pwdata[0];
        REG_NEVER_OFF:  cfg_r.never_off         <= cfg_pwdata[0];
        REG_MANUAL_BRT: cfg_r.manual_brightness <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_AUTO_MODE:  cfg_prdata = {31'd0, cfg_r.auto_mode};
      REG_NEVER_OFF:  cfg_prdata = {31'd0, cfg_r.never_off};
      REG_MANUAL_BRT: cfg_prdata = {24'd0, cfg_r.manual_brightness};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // Stage handshake: input register feeds the result register
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer)     s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (s1_adv)          out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_low_r  <= in_tdata[14:0];
      s1_mid_r  <= in_tdata[29:15];
      s1_high_r <= in_tdata[44:30];
      s1_hold_r <= in_tuser;
    end
  end

  alab_light u_light (
    .sum_low   (s1_low_r),
    .sum_mid   (s1_mid_r),
    .sum_high  (s1_high_r),
    .hold_on   (s1_hold_r),
    .never_off (cfg_r.never_off),
    .light     (light)
  );

  alab_level u_level (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .cfg        (cfg_r),
    .target     (light.target),
    .level_next (level_next),
    .changed    (level_changed)
  );

  // Result register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {2'b00, light.light_value, light.range_mode, light.target, level_next};
      out_user_r <= level_changed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

@@ rtl/alab_light.sv @@
// Range selection and brightness ladder for one sample set.
// Pure combinational; depends on alab_pkg.
`default_nettype none

module alab_light
  import alab_pkg::*;
(
  input  wire logic [SumW-1:0] sum_low,
  input  wire logic [SumW-1:0] sum_mid,
  input  wire logic [SumW-1:0] sum_high,
  input  wire logic            hold_on,
  input  wire logic            never_off,
  output alab_light_t          light
);

  logic [AvgW-1:0]  avg_low;
  logic [AvgW-1:0]  avg_mid;
  logic [AvgW-1:0]  avg_high;
  logic [1:0]       range_sel;
  logic [AvgW-1:0]  val_sel;
  logic [CodeW-1:0] code;
  logic [7:0]       tgt;

  // Divide each 8-sample sum by 8
  assign avg_low  = sum_low[SumW-1:3];
  assign avg_mid  = sum_mid[SumW-1:3];
  assign avg_high = sum_high[SumW-1:3];

  // First divider below the limit, high divider as fallback
  always_comb begin
    if (avg_low < AvgLimit) begin
      range_sel = RANGE_LOW;
      val_sel   = avg_low;
    end else if (avg_mid < AvgLimit) begin
      range_sel = RANGE_MID;
      val_sel   = avg_mid;
    end else begin
      range_sel = RANGE_HIGH;
      val_sel   = avg_high;
    end
  end

  // Range sits at bits [15:14] of the light code
  assign code = {range_sel, 2'b00, val_sel};

  // Ladder: the lowest threshold passed wins
  always_comb begin
    if (code < Thr255)      tgt = 8'd255;
    else if (code < Thr196) tgt = 8'd196;
    else if (code < Thr128) tgt = 8'd128;
    else if (code < Thr90)  tgt = 8'd90;
    else if (code < Thr40)  tgt = 8'd40;
    else if (code < Thr20)  tgt = 8'd20;
    else if (code < Thr10)  tgt = 8'd10;
    else if (code < Thr4)   tgt = 8'd4;
    else if (never_off || hold_on) tgt = 8'd1;
    else tgt = 8'd0;
  end

  assign light.target      = tgt;
  assign light.range_mode  = range_sel;
  assign light.light_value = val_sel;

endmodule

`default_nettype wire

@@ rtl/alab_level.sv @@
// Kept brightness level with direction-change countdowns.
// Depends on alab_pkg; updated once per item moved to the result register.
`default_nettype none

module alab_level
  import alab_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire alab_cfg_t  cfg,
  input  wire logic [7:0] target,
  output logic      [7:0] level_next,
  output logic            changed
);

  logic [7:0] level_r,     level_nxt;
  logic [1:0] rise_wait_r, rise_wait_nxt;
  logic [1:0] fall_wait_r, fall_wait_nxt;
  logic [8:0] lv_wide;
  logic [8:0] tg_wide;

  assign lv_wide = {1'b0, level_r};
  assign tg_wide = {1'b0, target};

  // Next level and countdowns
  always_comb begin
    level_nxt     = level_r;
    rise_wait_nxt = rise_wait_r;
    fall_wait_nxt = fall_wait_r;
    if (!cfg.auto_mode) begin
      level_nxt = cfg.manual_brightness;
    end else if (target < level_r) begin
      rise_wait_nxt = WaitTurn;
      if (fall_wait_r != 2'd0) begin
        fall_wait_nxt = fall_wait_r - 2'd1;
      end else if ((tg_wide + BigStepGap < lv_wide) && (level_r > BigDownMin)) begin
        level_nxt = level_r - BigStep;
      end else begin
        level_nxt = level_r - 8'd1;
      end
    end else if (target > level_r) begin
      fall_wait_nxt = WaitTurn;
      if (rise_wait_r != 2'd0) begin
        rise_wait_nxt = rise_wait_r - 2'd1;
      end else if (tg_wide > lv_wide + BigStepGap) begin
        level_nxt = level_r + BigStep;
      end else begin
        level_nxt = level_r + 8'd1;
      end
    end else begin
      rise_wait_nxt = WaitSteady;
      fall_wait_nxt = WaitSteady;
    end
  end

  assign level_next = level_nxt;
  assign changed    = (level_nxt != level_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LevelReset;
      rise_wait_r <= 2'd0;
      fall_wait_r <= 2'd0;
    end else if (step) begin
      level_r     <= level_nxt;
      rise_wait_r <= rise_wait_nxt;
      fall_wait_r <= fall_wait_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/alab_checker.sv @@
// Port-level checks for ambient_light_auto_brightness, attached by bind.
// Depends on alab_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module alab_checker
  import alab_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        cfg_pready
);

  logic [32:0] out_word;
  logic        out_stall;
  logic        avg_in_range;

  assign out_word     = {out_tuser, out_tdata};
  assign out_stall    = out_tvalid && !out_tready;
  assign avg_in_range = (out_tdata[17:16] == RANGE_HIGH) || (out_tdata[29:18] < AvgLimit);

  // A stalled result transfer keeps its payload
  `ASSERT_CLK(a_out_hold, out_stall |=> out_tvalid && $stable(out_word), "stalled result changed")

  // Both stages are empty right after a reset edge; checked on out_tvalid
  `ASSERT_CLK_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // Range code is one of the three dividers
  `ASSERT_CLK(a_range_code, out_tvalid |-> (out_tdata[17:16] <= RANGE_HIGH), "illegal range code")

  // The low and mid dividers are only chosen below the averaging limit
  `ASSERT_CLK(a_avg_limit, out_tvalid |-> avg_in_range, "chosen average above limit")

  // Register port never waits
  `ASSERT_CLK(a_pready, cfg_pready, "pready dropped")

endmodule

bind ambient_light_auto_brightness alab_checker u_alab_checker (.*);

`default_nettype wire

@@ sim/alab_checker.sv @@
// Checker for the ambient light auto brightness block: follows the input, result and
// register transfers, predicts each result and compares it with what the block returns.
// Depends on alab_pkg.
module alab_scoreboard
  import alab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,  // [14:0] sum_low_resistor, [29:15] sum_mid_resistor,
                                      // [44:30] sum_high_resistor, [47:45] zero
  input  wire logic        in_tuser,  // [0] hold_on
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata, // [7:0] brightness, [15:8] target_brightness,
                                      // [17:16] range_mode, [29:18] light_value, [31:30] zero
  input  wire logic        out_tuser, // [0] brightness_changed
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic [31:0] cfg_prdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  brightness;
    logic        changed;
    alab_light_t light;
  } brightness_report_t;

  // Shadow copy of the block's registers and level state
  alab_cfg_t  cfg_shadow;
  logic [7:0] level_now;
  logic [1:0] rise_hold;
  logic [1:0] fall_hold;

  brightness_report_t report_q[$];
  int failures = 0;
  int queued   = 0;

  assign fail_count = failures;
  assign pending    = queued;

  task automatic record_failure(input string msg);
    if (failures < 10) $display("%0t: %s", $time, msg);
    failures++;
  endtask

  // Averages, range choice, ladder and one step of the level tracker
  function automatic brightness_report_t predict_brightness(input logic [47:0] sums,
                                                            input logic hold);
    logic [AvgW-1:0]  avg_low;
    logic [AvgW-1:0]  avg_mid;
    logic [AvgW-1:0]  avg_high;
    logic [CodeW-1:0] code;
    logic [7:0]       next_level;
    int               lv;
    int               tg;
    brightness_report_t rep;

    avg_low  = sums[14:3];
    avg_mid  = sums[29:18];
    avg_high = sums[44:33];
    if (avg_low < AvgLimit) begin
      rep.light.range_mode  = RANGE_LOW;
      rep.light.light_value = avg_low;
    end else if (avg_mid < AvgLimit) begin
      rep.light.range_mode  = RANGE_MID;
      rep.light.light_value = avg_mid;
    end else begin
      rep.light.range_mode  = RANGE_HIGH;
      rep.light.light_value = avg_high;
    end
    code = {rep.light.range_mode, 2'b00, rep.light.light_value};

    // darker light means a smaller code and a brighter target
    rep.light.target = (cfg_shadow.never_off || hold) ? 8'd1 : 8'd0;
    if (code < Thr4)   rep.light.target = 8'd4;
    if (code < Thr10)  rep.light.target = 8'd10;
    if (code < Thr20)  rep.light.target = 8'd20;
    if (code < Thr40)  rep.light.target = 8'd40;
    if (code < Thr90)  rep.light.target = 8'd90;
    if (code < Thr128) rep.light.target = 8'd128;
    if (code < Thr196) rep.light.target = 8'd196;
    if (code < Thr255) rep.light.target = 8'd255;

    lv = level_now;
    tg = rep.light.target;
    next_level = level_now;
    if (cfg_shadow.auto_mode) begin
      if (tg < lv) begin
        rise_hold = 2'd3;
        if (fall_hold != 2'd0) fall_hold = fall_hold - 2'd1;
        else if (tg < lv - 9 && lv > 20) next_level = 8'(lv - 10);
        else next_level = 8'(lv - 1);
      end else if (tg > lv) begin
        fall_hold = 2'd3;
        if (rise_hold != 2'd0) rise_hold = rise_hold - 2'd1;
        else if (tg > lv + 9) next_level = 8'(lv + 10);
        else next_level = 8'(lv + 1);
      end else begin
        rise_hold = 2'd2;
        fall_hold = 2'd2;
      end
    end else begin
      // manual level; countdowns keep their values
      next_level = cfg_shadow.manual_brightness;
    end

    rep.changed    = (next_level != level_now);
    rep.brightness = next_level;
    level_now      = next_level;
    return rep;
  endfunction

  always @(posedge clk) begin
    brightness_report_t want;
    brightness_report_t got;
    logic [31:0]        reg_value;
    logic               reg_known;

    if (!rst_n) begin
      cfg_shadow.auto_mode         = 1'b1;
      cfg_shadow.never_off         = 1'b0;
      cfg_shadow.manual_brightness = LevelReset;
      level_now = LevelReset;
      rise_hold = 2'd0;
      fall_hold = 2'd0;
      report_q.delete();
    end else begin
      // register port access phase
      if (cfg_psel && cfg_penable && cfg_pready) begin
        reg_known = 1'b1;
        reg_value = '0;
        case (cfg_paddr[3:2])
          REG_AUTO_MODE:  reg_value = {31'b0, cfg_shadow.auto_mode};
          REG_NEVER_OFF:  reg_value = {31'b0, cfg_shadow.never_off};
          REG_MANUAL_BRT: reg_value = {24'b0, cfg_shadow.manual_brightness};
          default:        reg_known = 1'b0;
        endcase
        if (cfg_pwrite) begin
          case (cfg_paddr[3:2])
            REG_AUTO_MODE:  cfg_shadow.auto_mode         = cfg_pwdata[0];
            REG_NEVER_OFF:  cfg_shadow.never_off         = cfg_pwdata[0];
            REG_MANUAL_BRT: cfg_shadow.manual_brightness = cfg_pwdata[7:0];
            default: ;
          endcase
        end else if (reg_known && cfg_prdata !== reg_value) begin
          record_failure($sformatf("register read at 0x%0h: expected 0x%0h, got 0x%0h",
                                   cfg_paddr, reg_value, cfg_prdata));
        end
      end

      // result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.brightness        = out_tdata[7:0];
        got.light.target      = out_tdata[15:8];
        got.light.range_mode  = out_tdata[17:16];
        got.light.light_value = out_tdata[29:18];
        got.changed           = out_tuser;
        if (report_q.size() == 0) begin
          record_failure($sformatf("result with nothing expected: tdata 0x%0h tuser %0b",
                                   out_tdata, out_tuser));
        end else begin
          want = report_q.pop_front();
          if (got !== want)
            record_failure($sformatf({"result mismatch (expected/actual): brightness %0d/%0d",
                                      " changed %0b/%0b target %0d/%0d range %0d/%0d",
                                      " light %0d/%0d"},
                                     want.brightness, got.brightness,
                                     want.changed, got.changed,
                                     want.light.target, got.light.target,
                                     want.light.range_mode, got.light.range_mode,
                                     want.light.light_value, got.light.light_value));
        end
      end

      if (in_tvalid && in_tready) report_q.push_back(predict_brightness(in_tdata, in_tuser));
    end
    queued <= report_q.size();
  end

endmodule

@@ sim/testbench.sv @@
// Top of the ambient light auto brightness simulation: clock, reset, stimulus on the
// sample, result and register ports, and the verdict. Depends on alab_pkg, the block
// and alab_scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import alab_pkg::*;

  localparam int         CycleLimit = 200000;
  localparam int         LongHold   = 60;
  localparam logic [1:0] RegUnused  = 2'd3;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata  = '0;  // [14:0] low sum, [29:15] mid sum, [44:30] high sum
  logic        in_tuser  = 1'b0; // [0] hold_on
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [7:0] brightness, [15:8] target, [17:16] range,
                                 // [29:18] light value
  logic        out_tuser;        // [0] brightness_changed
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int cycle_count   = 0;
  bit sender_steady = 1'b0;
  bit stall_request = 1'b0;

  ambient_light_auto_brightness dut (.*);
  alab_scoreboard u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, bursts without stalls, one long hold on request
  initial begin
    int gap;
    int served;
    bit steady;
    served = 0;
    steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (stall_request) begin
        out_tready    <= 1'b0;
        stall_request <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      if (served % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      served++;
    end
  end

  // One sample-set transfer after a random gap, or none while the sender is steady
  task automatic send_sums(input logic [14:0] s_low, input logic [14:0] s_mid,
                           input logic [14:0] s_high, input logic hold);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, s_high, s_mid, s_low};
    in_tuser  <= hold;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // Sample set whose chosen divider and average are given; the rest is filler
  task automatic send_light(input logic [1:0] rng, input int val, input logic hold);
    logic [14:0] picked;
    logic [14:0] s_low;
    logic [14:0] s_mid;
    logic [14:0] s_high;
    picked = 15'(val * 8 + $urandom_range(0, 7));
    s_low  = 15'($urandom_range(32000, 32767));
    s_mid  = 15'($urandom_range(32000, 32767));
    s_high = 15'($urandom);
    case (rng)
      RANGE_LOW: begin
        s_low = picked;
        s_mid = 15'($urandom);
      end
      RANGE_MID: s_mid  = picked;
      default:   s_high = picked;
    endcase
    send_sums(s_low, s_mid, s_high, hold);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // APB transfer; psel stays high so transfers can follow back to back
  task automatic reg_access(input logic [1:0] index, input logic write,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // Write all registers with junk in the unused bits, then read them back
  task automatic set_config(input logic auto_on, input logic floor_one,
                            input logic [7:0] manual);
    reg_access(REG_AUTO_MODE,  1'b1, {31'($urandom), auto_on});
    reg_access(REG_NEVER_OFF,  1'b1, {31'($urandom), floor_one});
    reg_access(REG_MANUAL_BRT, 1'b1, {24'($urandom), manual});
    reg_access(REG_AUTO_MODE,  1'b0, '0);
    reg_access(REG_NEVER_OFF,  1'b0, '0);
    reg_access(REG_MANUAL_BRT, 1'b0, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Runs of similar light with jitter, mostly near ladder edges, plus noise
  task automatic run_scenes(input int count, input int stall_at, input int pause_at);
    int   sent;
    int   run_len;
    int   step;
    int   val;
    int   top_val;
    logic [1:0] rng;
    logic hold;
    sent = 0;
    while (sent < count) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(8, 40);
      hold = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        rng = 2'($urandom_range(0, 2));
        val = $urandom_range(0, 3999);
      end else begin
        case ($urandom_range(0, 8))
          0: begin rng = RANGE_HIGH; val = 3300; end
          1: begin rng = RANGE_HIGH; val = 3170; end
          2: begin rng = RANGE_HIGH; val = 3000; end
          3: begin rng = RANGE_HIGH; val = 2000; end
          4: begin rng = RANGE_HIGH; val = 400; end
          5: begin rng = RANGE_MID;  val = 2000; end
          6: begin rng = RANGE_MID;  val = 1120; end
          7: begin rng = RANGE_MID;  val = 0; end
          default: begin rng = RANGE_LOW; val = 3999; end
        endcase
      end
      top_val = (rng == RANGE_HIGH) ? 4095 : 3999;
      for (step = 0; step < run_len && sent < count; step++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_sums(15'($urandom), 15'($urandom), 15'($urandom), 1'($urandom));
        end else begin
          val += int'($urandom_range(0, 6)) - 3;
          if (val < 0) val = 0;
          if (val > top_val) val = top_val;
          send_light(rng, val, hold);
        end
        sent++;
        if (sent == stall_at) stall_request <= 1'b1;
        if (sent == pause_at) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, and a write to an unmapped index that must change nothing
    set_config(1'b1, 1'b0, LevelReset);
    reg_access(RegUnused, 1'b1, 32'hFFFF_FFFF);
    set_config(1'b1, 1'b0, LevelReset);

    // field extremes, the 4000 range limit and both sides of every ladder step
    send_sums(15'd0, 15'd0, 15'd0, 1'b0);
    send_sums(15'd0, 15'd0, 15'd0, 1'b1);
    send_sums(15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b0);
    send_sums(15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b1);
    send_sums(15'd31999, 15'd0, 15'h7FFF, 1'b0);
    send_sums(15'd32000, 15'd31999, 15'h7FFF, 1'b1);
    send_sums(15'd32000, 15'd32000, 15'd0, 1'b0);
    send_light(RANGE_MID, 0, 1'b0);
    send_light(RANGE_MID, 1119, 1'b0);
    send_light(RANGE_MID, 1120, 1'b1);
    send_light(RANGE_MID, 1999, 1'b0);
    send_light(RANGE_MID, 2000, 1'b0);
    send_light(RANGE_HIGH, 399, 1'b0);
    send_light(RANGE_HIGH, 400, 1'b0);
    send_light(RANGE_HIGH, 1999, 1'b0);
    send_light(RANGE_HIGH, 2000, 1'b1);
    send_light(RANGE_HIGH, 2999, 1'b0);
    send_light(RANGE_HIGH, 3000, 1'b0);
    send_light(RANGE_HIGH, 3169, 1'b0);
    send_light(RANGE_HIGH, 3170, 1'b0);
    send_light(RANGE_HIGH, 3299, 1'b1);
    send_light(RANGE_HIGH, 3300, 1'b0);
    send_light(RANGE_HIGH, 4095, 1'b0);
    run_scenes(240, 30, -1);
    wait_drained();

    set_config(1'b0, 1'b0, 8'd0);
    run_scenes(100, -1, -1);
    wait_drained();

    set_config(1'b1, 1'b0, 8'($urandom));
    run_scenes(200, -1, -1);
    wait_drained();

    set_config(1'b0, 1'b1, 8'd255);
    run_scenes(100, -1, -1);
    wait_drained();

    set_config(1'b1, 1'b1, 8'($urandom));
    run_scenes(260, -1, 120);
    wait_drained();

    set_config(1'b0, 1'b0, 8'($urandom));
    run_scenes(80, -1, -1);
    wait_drained();

    set_config(1'b1, 1'b0, LevelReset);
    run_scenes(300, 150, -1);
    wait_drained();

    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/alab_pkg.sv
rtl/alab_light.sv
rtl/alab_level.sv
rtl/ambient_light_auto_brightness.sv
rtl/alab_checker.sv
sim/alab_checker.sv
sim/testbench.sv
